### rtl/svd_pkg.sv
// shared widths, command and register codes for the soft viterbi decoder
// no dependencies
package svd_pkg;
	localparam int SYM_W   = 8;
	localparam int BITS_W  = 32;
	localparam int GAIN_W  = 15;
	localparam int CFG_W   = 7;
	localparam int CFG_IW  = 2;
	localparam int POLY_W  = 7;
	localparam int DEPTH_W = 6;

	localparam logic CMD_SYMBOLS = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	localparam logic [CFG_IW-1:0] REG_POLY_FIRST  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_POLY_SECOND = 2'd1;
	localparam logic [CFG_IW-1:0] REG_TB_DEPTH    = 2'd2;
	localparam logic [CFG_IW-1:0] REG_CHUNK_SIZE  = 2'd3;

	// parity of a shift register masked by a generator, up to nine taps
	function automatic logic tap_parity(input logic [8:0] sr, input logic [8:0] poly);
		return ^(sr & poly);
	endfunction
endpackage

### rtl/svd_if.sv
// valid/ready channels for symbol words and decoded words
// depends on svd_pkg
interface svd_sym_if;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [svd_pkg::SYM_W-1:0] sym_first;
	logic [svd_pkg::SYM_W-1:0] sym_second;
	modport source (output valid, command, sym_first, sym_second, input ready);
	modport sink   (input valid, command, sym_first, sym_second, output ready);
endinterface

interface svd_res_if;
	logic                              valid;
	logic                              ready;
	logic        [svd_pkg::BITS_W-1:0] decoded_bits;
	logic signed [svd_pkg::GAIN_W-1:0] path_metric;
	modport source (output valid, decoded_bits, path_metric, input ready);
	modport sink   (input valid, decoded_bits, path_metric, output ready);
endinterface

### rtl/svd_ram.sv
// generic synchronous ram, one write port, NRD registered read ports
// no dependencies
module svd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int NRD   = 1
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(DEPTH)-1:0]           waddr,
	input  logic [WIDTH-1:0]                   wdata,
	input  logic [NRD-1:0][$clog2(DEPTH)-1:0]  raddr,
	output logic [NRD-1:0][WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		for (int i = 0; i < NRD; i++) begin
			rdata[i] <= mem[raddr[i]];
		end
	end
endmodule

### rtl/soft_viterbi_decoder_rate_half.sv
// top level of the rate 1/2 soft-decision viterbi decoder
// depends on svd_pkg, svd_if (svd_sym_if, svd_res_if) and svd_ram
//
// channel  dir  word                                   note
// sym      in   command, sym_first, sym_second         one trellis step or a clear
// res      out  decoded_bits, path_metric              one word per chunk boundary
// cfg      in   cfg_we, cfg_index, cfg_data            poly/depth/chunk registers
//
// a symbol word holds off the next input while it is accepted, run through
// add-compare-select over every state (two metric reads per cycle) and
// the remainder of the pointer by chunk_size is settled; the remainder is
// worked out by subtraction alongside the add-compare-select
// at a chunk boundary a traceback through the metric/decision ram and the
// bit read-out follow
// reset and clear drop one valid bit per path row,
// so no clearing pass is run
// a full output register only stalls the last step of a traceback
module soft_viterbi_decoder_rate_half #(
	parameter int CONSTRAINT_LENGTH = 7,
	parameter int PATH_DEPTH        = 64,
	parameter int METRIC_WIDTH      = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	svd_sym_if.sink                     sym,
	svd_res_if.source                   res,
	input  logic                        cfg_we,
	input  logic [svd_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [svd_pkg::CFG_W-1:0]   cfg_data
);
	localparam int SW  = CONSTRAINT_LENGTH - 1;
	localparam int NST = 1 << SW;
	localparam int PW  = $clog2(PATH_DEPTH);
	localparam int AW  = PW + SW;
	localparam int MW  = METRIC_WIDTH;
	localparam int RW  = (PW > svd_pkg::DEPTH_W) ? PW : svd_pkg::DEPTH_W;
	localparam logic [PW-1:0] ROW_LAST = PW'(PATH_DEPTH - 1);
	localparam logic [svd_pkg::DEPTH_W-1:0] DEPTH_RST =
		svd_pkg::DEPTH_W'((PATH_DEPTH - 1 > 63) ? 63 : PATH_DEPTH - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ACS  = 4'd1;
	localparam logic [3:0] S_MOD  = 4'd2;
	localparam logic [3:0] S_TBI  = 4'd3;
	localparam logic [3:0] S_TBR  = 4'd4;
	localparam logic [3:0] S_TBW  = 4'd5;
	localparam logic [3:0] S_FIN  = 4'd6;
	localparam logic [3:0] S_BITS = 4'd7;
	localparam logic [3:0] S_GAIN = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	// wrapping row arithmetic, depth need not be a power of two
	function automatic logic [PW-1:0] row_inc(input logic [PW-1:0] r);
		return (r == ROW_LAST) ? '0 : PW'(r + 1'b1);
	endfunction
	function automatic logic [PW-1:0] row_dec(input logic [PW-1:0] r);
		return (r == '0) ? ROW_LAST : PW'(r - 1'b1);
	endfunction
	// modulo comparison of metrics
	function automatic logic m_greater(input logic [MW-1:0] a, input logic [MW-1:0] b);
		logic [MW-1:0] d;
		d = a - b;
		return !d[MW-1] && (d != '0);
	endfunction

	// configuration registers
	logic [svd_pkg::POLY_W-1:0]  poly_first_q, poly_second_q;
	logic [svd_pkg::DEPTH_W-1:0] tb_depth_q, chunk_q;
	logic [svd_pkg::DEPTH_W-1:0] cfg_val6;
	assign cfg_val6 = cfg_data[svd_pkg::DEPTH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_first_q  <= svd_pkg::POLY_W'(109);
			poly_second_q <= svd_pkg::POLY_W'(79);
			tb_depth_q    <= DEPTH_RST;
			chunk_q       <= svd_pkg::DEPTH_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				svd_pkg::REG_POLY_FIRST:  poly_first_q  <= cfg_data;
				svd_pkg::REG_POLY_SECOND: poly_second_q <= cfg_data;
				svd_pkg::REG_TB_DEPTH: begin
					if (32'(cfg_val6) <= 32'(PATH_DEPTH - 1)) tb_depth_q <= cfg_val6;
				end
				svd_pkg::REG_CHUNK_SIZE: begin
					if (cfg_val6 != '0 && cfg_val6 <= 6'd32 && cfg_val6 <= tb_depth_q)
						chunk_q <= cfg_val6;
				end
				default: ;
			endcase
		end
	end

	// control and datapath registers
	logic [3:0]            state_q;
	logic [PATH_DEPTH-1:0] row_valid_q;   // a row not yet written since clear reads as zero
	logic [PW-1:0]         wp_q, cur_q, prev_q, nwp_q;
	logic [RW-1:0]         rem_q;
	logic [SW:0]           iss_q;
	logic [svd_pkg::SYM_W-1:0] s0_q, s1_q;
	logic                  acs_v_s1;
	logic [SW-1:0]         acs_st_s1;
	logic                  ok_a_s1;
	logic [SW-1:0]         best_q;
	logic [MW-1:0]         best_m_q;
	logic [PW-1:0]         p_q, rp_q;
	logic [SW-1:0]         st_q;
	logic [svd_pkg::DEPTH_W-1:0] i_q, j_q;
	logic [MW-1:0]         start_q;
	logic [svd_pkg::BITS_W-1:0] bits_q;
	logic signed [svd_pkg::GAIN_W-1:0] gain_q;
	logic                  ov_q;
	logic [svd_pkg::BITS_W-1:0] obits_q;
	logic signed [svd_pkg::GAIN_W-1:0] ogain_q;

	// metric/decision ram: {decision, metric} per row and state
	logic                      mm_we;
	logic [AW-1:0]             mm_waddr;
	logic [MW:0]               mm_wdata;
	logic [1:0][AW-1:0]        mm_raddr;
	logic [1:0][MW:0]          mm_rdata;
	logic [PW-1:0]             row_a;

	// traced-state ram
	logic                      tr_we;
	logic [PW-1:0]             tr_waddr;
	logic [SW-1:0]             tr_wdata;
	logic [0:0][PW-1:0]        tr_raddr;
	logic [0:0][SW-1:0]        tr_rdata;

	svd_ram #(.WIDTH(MW + 1), .DEPTH(PATH_DEPTH * NST), .NRD(2)) u_metric_ram (
		.clk(clk), .we(mm_we), .waddr(mm_waddr), .wdata(mm_wdata),
		.raddr(mm_raddr), .rdata(mm_rdata)
	);

	svd_ram #(.WIDTH(SW), .DEPTH(PATH_DEPTH), .NRD(1)) u_trace_ram (
		.clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
		.raddr(tr_raddr), .rdata(tr_rdata)
	);

	// add-compare-select datapath for the state in the write stage
	logic [MW-1:0] old0, old1, new0, new1, acs_m;
	logic          acs_dec;
	logic [SW-1:0] p0_s1, p1_s1;

	function automatic logic [MW-1:0] branch_add(
		input logic [SW-1:0] p, input logic eb,
		input logic [svd_pkg::POLY_W-1:0] pf, input logic [svd_pkg::POLY_W-1:0] ps,
		input logic [svd_pkg::SYM_W-1:0] s0, input logic [svd_pkg::SYM_W-1:0] s1);
		logic [8:0]         sr;
		logic               c0, c1;
		logic signed [9:0]  e0, e1, d0, d1, sum;
		sr  = 9'({p, eb});
		c0  = svd_pkg::tap_parity(sr, 9'(pf));
		c1  = svd_pkg::tap_parity(sr, 9'(ps));
		e0  = signed'({2'b00, s0});
		e1  = signed'({2'b00, s1});
		d0  = c0 ? (e0 - 10'sd128) : (10'sd128 - e0);
		d1  = c1 ? (e1 - 10'sd128) : (10'sd128 - e1);
		sum = d0 + d1;
		return MW'(sum);
	endfunction

	always_comb begin
		p0_s1 = {1'b0, acs_st_s1[SW-1:1]};
		p1_s1 = {1'b1, acs_st_s1[SW-1:1]};
		old0  = ok_a_s1 ? mm_rdata[0][MW-1:0] : '0;
		old1  = ok_a_s1 ? mm_rdata[1][MW-1:0] : '0;
		new0  = old0 + branch_add(p0_s1, acs_st_s1[0], poly_first_q, poly_second_q, s0_q, s1_q);
		new1  = old1 + branch_add(p1_s1, acs_st_s1[0], poly_first_q, poly_second_q, s0_q, s1_q);
		// ties go to the predecessor with its oldest bit set
		acs_dec = !m_greater(new0, new1);
		acs_m   = acs_dec ? new1 : new0;
	end

	// traced data and decision bit seen by the traceback
	logic          tb_dec;
	logic [SW-1:0] tb_pred;
	logic [SW-1:0] t_st;
	logic [MW-1:0] end_m, diff_m;
	logic signed [32:0] diff_x;
	logic signed [svd_pkg::GAIN_W-1:0] gain_c;

	always_comb begin
		tb_dec  = ok_a_s1 ? mm_rdata[0][MW] : 1'b0;
		tb_pred = {tb_dec, st_q[SW-1:1]};
		t_st    = tr_rdata[0];
		end_m   = ok_a_s1 ? mm_rdata[0][MW-1:0] : '0;
		diff_m  = end_m - start_q;
		diff_x  = 33'(signed'(diff_m));
		if (diff_x > 33'sd16383)       gain_c = 15'sd16383;
		else if (diff_x < -33'sd16384) gain_c = -15'sd16384;
		else                           gain_c = diff_x[svd_pkg::GAIN_W-1:0];
	end

	// ram address selection
	always_comb begin
		row_a       = prev_q;
		mm_raddr[0] = {prev_q, 1'b0, iss_q[SW-1:1]};
		mm_raddr[1] = {prev_q, 1'b1, iss_q[SW-1:1]};
		unique case (state_q)
			S_TBR, S_FIN: begin
				row_a       = p_q;
				mm_raddr[0] = {p_q, st_q};
			end
			S_BITS: begin
				row_a       = rp_q;
				mm_raddr[0] = {rp_q, t_st};
			end
			default: ;
		endcase

		mm_we    = acs_v_s1;
		mm_waddr = {cur_q, acs_st_s1};
		mm_wdata = {acs_dec, acs_m};

		tr_we    = 1'b0;
		tr_waddr = cur_q;
		tr_wdata = best_q;
		if (state_q == S_TBW) begin
			tr_we    = 1'b1;
			tr_waddr = row_dec(p_q);
			tr_wdata = tb_pred;
		end else if (state_q == S_TBI) begin
			tr_we    = 1'b1;
		end
		tr_raddr[0] = (state_q == S_FIN) ? p_q : row_inc(rp_q);
	end

	// the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_valid_q <= '0;
			wp_q        <= '0;
			acs_v_s1    <= 1'b0;
			ov_q        <= 1'b0;
			iss_q       <= '0;
		end else begin
			ok_a_s1  <= row_valid_q[row_a];
			acs_v_s1 <= (state_q == S_ACS) && (iss_q != (SW+1)'(NST));
			// output word loads in the last traceback step, empties when taken
			ov_q     <= (state_q == S_OUT && (!ov_q || res.ready)) || (ov_q && !res.ready);

			// pointer remainder by chunk size, one subtraction a cycle
			if ((state_q == S_ACS || state_q == S_MOD) && rem_q >= RW'(chunk_q))
				rem_q <= rem_q - RW'(chunk_q);

			// best state over the freshly written row, first maximum wins
			if (acs_v_s1) begin
				if (acs_st_s1 == '0 || m_greater(acs_m, best_m_q)) begin
					best_q   <= acs_st_s1;
					best_m_q <= acs_m;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (sym.valid) begin
						if (sym.command == svd_pkg::CMD_CLEAR) begin
							row_valid_q <= '0;
							wp_q        <= '0;
						end else begin
							s0_q    <= sym.sym_first;
							s1_q    <= sym.sym_second;
							cur_q   <= wp_q;
							prev_q  <= row_dec(wp_q);
							nwp_q   <= row_inc(wp_q);
							rem_q   <= RW'(row_inc(wp_q));
							iss_q   <= '0;
							state_q <= S_ACS;
						end
					end
				end
				S_ACS: begin
					if (iss_q != (SW+1)'(NST)) begin
						iss_q     <= iss_q + 1'b1;
						acs_st_s1 <= iss_q[SW-1:0];
					end else if (!acs_v_s1) begin
						row_valid_q[cur_q] <= 1'b1;
						wp_q    <= nwp_q;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (rem_q < RW'(chunk_q))
						state_q <= (rem_q == '0) ? S_TBI : S_IDLE;
				end
				S_TBI: begin
					p_q     <= cur_q;
					st_q    <= best_q;
					i_q     <= '0;
					state_q <= (tb_depth_q == '0) ? S_FIN : S_TBR;
				end
				S_TBR: state_q <= S_TBW;
				S_TBW: begin
					p_q     <= row_dec(p_q);
					st_q    <= tb_pred;
					i_q     <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 == tb_depth_q) ? S_FIN : S_TBR;
				end
				S_FIN: begin
					rp_q    <= p_q;
					j_q     <= '0;
					bits_q  <= '0;
					state_q <= S_BITS;
				end
				S_BITS: begin
					if (j_q == '0) start_q <= ok_a_s1 ? mm_rdata[0][MW-1:0] : '0;
					if (j_q != chunk_q) begin
						bits_q <= {bits_q[svd_pkg::BITS_W-2:0], t_st[0]};
						rp_q   <= row_inc(rp_q);
						j_q    <= j_q + 1'b1;
					end else begin
						state_q <= S_GAIN;
					end
				end
				S_GAIN: begin
					gain_q  <= gain_c;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ov_q || res.ready) begin
						obits_q <= bits_q;
						ogain_q <= gain_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sym.ready        = (state_q == S_IDLE);
	assign res.valid        = ov_q;
	assign res.decoded_bits = obits_q;
	assign res.path_metric  = ogain_q;
endmodule

### dv/tb_soft_viterbi_decoder_rate_half.sv
// self-checking testbench for soft_viterbi_decoder_rate_half
// depends on svd_pkg, svd_sym_if, svd_res_if and the decoder rtl
// a bit-true trellis predictor in a scoreboard class checks every decoded word
module tb_soft_viterbi_decoder_rate_half;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NST          = 64;
	localparam int PDEPTH       = 64;
	localparam int DRAIN_CYCLES = 340;     // worst symbol step plus a full traceback
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int HOLD_CYCLES  = 1500;

	typedef struct {
		logic        [svd_pkg::BITS_W-1:0] bits;
		logic signed [svd_pkg::GAIN_W-1:0] gain;
	} chunk_word_t;

	// trellis predictor plus the queue of words it expects
	class viterbi_scoreboard;
		logic [15:0] pmetric [NST][PDEPTH];
		bit          pdecide [NST][PDEPTH];
		logic [5:0]  trace_st[PDEPTH];
		bit   [63:0] trace_written;
		logic [5:0]  wptr;
		logic [6:0]  gen_first, gen_second;
		logic [5:0]  tb_depth, chunk;
		chunk_word_t expected_words[$];
		int          errors, words_checked;

		function new();
			clear_paths();
			trace_written = '0;
			gen_first = 7'd109;
			gen_second = 7'd79;
			tb_depth = 6'd63;
			chunk = 6'd8;
		endfunction

		function void clear_paths();
			foreach (pmetric[i, j]) begin
				pmetric[i][j] = '0;
				pdecide[i][j] = 1'b0;
			end
			wptr = '0;
		endfunction

		function void write_reg(logic [svd_pkg::CFG_IW-1:0] idx,
				logic [svd_pkg::CFG_W-1:0] val);
			case (idx)
				svd_pkg::REG_POLY_FIRST: gen_first = val;
				svd_pkg::REG_POLY_SECOND: gen_second = val;
				svd_pkg::REG_TB_DEPTH: tb_depth = val[5:0];
				svd_pkg::REG_CHUNK_SIZE: begin
					if (val[5:0] >= 1 && val[5:0] <= 32 && val[5:0] <= tb_depth)
						chunk = val[5:0];
				end
			endcase
		endfunction

		function logic [1:0] code_pair(logic [5:0] s, logic b);
			logic [6:0] sr;
			sr = {s, b};
			return {^(sr & gen_second), ^(sr & gen_first)};
		endfunction

		function bit ahead(logic [15:0] a, logic [15:0] b);
			logic [15:0] d;
			d = a - b;
			return $signed(d) > 0;
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		function void note(logic cmd, logic [svd_pkg::SYM_W-1:0] s0,
				logic [svd_pkg::SYM_W-1:0] s1);
			int          add[4];
			logic [5:0]  cur, prv, best, p, p0, p1;
			logic [15:0] m0, m1, base, diff;
			logic [31:0] bits;
			int          g;
			chunk_word_t w;
			if (cmd == svd_pkg::CMD_CLEAR) begin
				clear_paths();
				return;
			end
			add[0] = (128 - s1) + (128 - s0);
			add[1] = (128 - s1) + (s0 - 128);
			add[2] = (s1 - 128) + (128 - s0);
			add[3] = (s1 - 128) + (s0 - 128);
			cur = wptr;
			prv = cur - 6'd1;
			for (int st = 0; st < NST; st++) begin
				p0 = 6'(st >> 1);
				p1 = p0 | 6'd32;
				m0 = pmetric[prv][p0] + 16'(add[code_pair(p0, st[0])]);
				m1 = pmetric[prv][p1] + 16'(add[code_pair(p1, st[0])]);
				pmetric[cur][st] = ahead(m0, m1) ? m0 : m1;
				pdecide[cur][st] = !ahead(m0, m1);
			end
			wptr = cur + 6'd1;
			if ((int'(wptr) % int'(chunk)) != 0)
				return;
			best = '0;
			for (int st = 1; st < NST; st++)
				if (ahead(pmetric[cur][st], pmetric[cur][best]))
					best = 6'(st);
			// trace back from the best state
			p = cur;
			trace_st[p] = best;
			trace_written[p] = 1'b1;
			for (int i = 0; i < tb_depth; i++) begin
				trace_st[p - 6'd1] = {pdecide[p][trace_st[p]], trace_st[p][5:1]};
				trace_written[p - 6'd1] = 1'b1;
				p = p - 6'd1;
			end
			base = pmetric[p][trace_st[p]];
			bits = '0;
			for (int i = 0; i < chunk; i++) begin
				bits = {bits[30:0], trace_st[p][0]};
				p = p + 6'd1;
			end
			diff = pmetric[p][trace_st[p]] - base;
			g = $signed(diff);
			if (g > 16383) g = 16383;
			if (g < -16384) g = -16384;
			w.bits = bits;
			w.gain = svd_pkg::GAIN_W'(g);
			expected_words.push_back(w);
		endfunction

		task check(logic [svd_pkg::BITS_W-1:0] bits,
				logic signed [svd_pkg::GAIN_W-1:0] gain);
			chunk_word_t w;
			words_checked++;
			if (expected_words.size() == 0) begin
				report($sformatf("decoded word %h/%0d with nothing expected", bits, gain));
				return;
			end
			w = expected_words.pop_front();
			if (bits !== w.bits)
				report($sformatf("decoded_bits %h, expected %h", bits, w.bits));
			if (gain !== w.gain)
				report($sformatf("path_metric %0d, expected %0d", gain, w.gain));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic                         cfg_we;
	logic [svd_pkg::CFG_IW-1:0]   cfg_index;
	logic [svd_pkg::CFG_W-1:0]    cfg_data;

	svd_sym_if sym ();
	svd_res_if res ();

	viterbi_scoreboard sb = new();

	// stimulus side bookkeeping
	int         words_in;
	int         settings_used;
	int         cycles;
	int         holds_asked, holds_done, hold_left;
	bit         steady;          // no random idling on either side while set
	logic [5:0] enc_state;       // encoder that builds well-formed streams

	soft_viterbi_decoder_rate_half dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym       (sym),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("soft_viterbi_decoder_rate_half verification failed");
			$finish;
		end
	end

	// receiver: random back-pressure, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (holds_asked != holds_done) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= steady || ($urandom_range(99) >= 38);
		end
	end

	// every accepted decoded word goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check(res.decoded_bits, res.path_metric);
	end

	// one symbol word or clear, with random idling before it
	task automatic send_word(input logic cmd, input logic [svd_pkg::SYM_W-1:0] a,
			input logic [svd_pkg::SYM_W-1:0] b);
		while (!steady && $urandom_range(99) < 38) begin
			sym.valid <= 1'b0;
			@(posedge clk);
		end
		sym.valid <= 1'b1;
		sym.command <= cmd;
		sym.sym_first <= a;
		sym.sym_second <= b;
		@(posedge clk);
		while (!sym.ready)
			@(posedge clk);
		sb.note(cmd, a, b);
		words_in++;
		if (cmd == svd_pkg::CMD_CLEAR)
			enc_state = '0;
	endtask

	// soft value of one code bit: mostly clean, some noise, erasures and flips
	function automatic logic [svd_pkg::SYM_W-1:0] soft_of(logic c);
		int r, v;
		r = $urandom_range(99);
		v = $urandom_range(0, 90);
		if (r < 5)
			return 8'd128;
		if (r < 8)
			c = !c;
		return c ? 8'(255 - v) : 8'(v);
	endfunction

	// encode one random information bit with the current generators
	task automatic send_coded();
		logic       b;
		logic [1:0] c;
		b = $urandom_range(1);
		c = sb.code_pair(enc_state, b);
		enc_state = {enc_state[4:0], b};
		send_word(svd_pkg::CMD_SYMBOLS, soft_of(c[0]), soft_of(c[1]));
	endtask

	task automatic send_random_item();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			send_word(svd_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom));
		else if (r < 13)
			send_word(svd_pkg::CMD_SYMBOLS, 8'($urandom), 8'($urandom));
		else
			send_coded();
	endtask

	// lower valid once the last word is taken, then wait for every decoded word
	task automatic drain();
		sym.valid <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [svd_pkg::CFG_IW-1:0] idx,
			input logic [svd_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// a traceback shorter than the chunk reads old traced states, so only
	// allow that once every entry has been written
	task automatic set_regs(input logic [6:0] g1, input logic [6:0] g2,
			input logic [6:0] d, input logic [6:0] c);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(svd_pkg::REG_POLY_FIRST, g1);
		write_reg(svd_pkg::REG_POLY_SECOND, g2);
		write_reg(svd_pkg::REG_TB_DEPTH, d);
		write_reg(svd_pkg::REG_CHUNK_SIZE, c);
		if (sb.tb_depth < sb.chunk && sb.trace_written != '1)
			write_reg(svd_pkg::REG_TB_DEPTH, 7'd63);
		cfg_we <= 1'b0;
		enc_state = '0;
		settings_used++;
	endtask

	// random words with a calm stretch and a full drain in the middle
	task automatic run_phase(input int n);
		for (int i = 0; i < n; i++) begin
			steady = (i >= n / 4) && (i < n / 3);
			if (i == n / 2)
				drain();
			send_random_item();
		end
		steady = 1'b0;
	endtask

	initial begin
		logic [6:0] g1, g2, d, c;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sym.valid <= 1'b0;
		sym.command <= svd_pkg::CMD_SYMBOLS;
		sym.sym_first <= '0;
		sym.sym_second <= '0;
		enc_state = '0;
		steady = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		settings_used = 1;

		// directed: strong zeros reach the first chunk boundary at reset settings
		for (int i = 0; i < 8; i++)
			send_word(svd_pkg::CMD_SYMBOLS, 8'd0, 8'd0);
		send_word(svd_pkg::CMD_SYMBOLS, 8'd255, 8'd255);
		send_word(svd_pkg::CMD_SYMBOLS, 8'd0, 8'd255);
		send_word(svd_pkg::CMD_SYMBOLS, 8'd255, 8'd0);
		send_word(svd_pkg::CMD_SYMBOLS, 8'd128, 8'd128);
		send_word(svd_pkg::CMD_SYMBOLS, 8'd0, 8'd128);
		send_word(svd_pkg::CMD_SYMBOLS, 8'd128, 8'd255);
		send_word(svd_pkg::CMD_SYMBOLS, 8'd255, 8'd128);
		send_word(svd_pkg::CMD_SYMBOLS, 8'd127, 8'd129);
		// clear at a chunk boundary, with symbol bits set
		send_word(svd_pkg::CMD_CLEAR, 8'd255, 8'd255);
		for (int i = 0; i < 9; i++)
			send_coded();
		run_phase(110);

		// all-zero generators: every branch ties, long chunk
		set_regs(7'd0, 7'd0, 7'd63, 7'd32);
		run_phase(110);

		// all-one generators, one bit per traceback; receiver holds off
		// so the output fills and the input stalls
		set_regs(7'd127, 7'd127, 7'd32, 7'd1);
		holds_asked++;
		run_phase(110);

		// shortest traceback, chunk kept from before; out-of-range chunk ignored
		set_regs(7'd109, 7'd79, 7'd63, 7'd32);
		set_regs(7'd91, 7'd121, 7'd0, 7'd40);
		run_phase(110);

		// rejected chunk writes of zero and above 32, depth through the top bit
		set_regs(7'd109, 7'd79, 7'h7F, 7'd0);
		write_reg(svd_pkg::REG_CHUNK_SIZE, 7'd33);
		write_reg(svd_pkg::REG_CHUNK_SIZE, 7'd3);
		cfg_we <= 1'b0;
		run_phase(110);

		for (int ph = 0; ph < 9; ph++) begin
			g1 = $urandom_range(3) == 0 ? ($urandom_range(1) ? 7'd127 : 7'd0) : 7'($urandom);
			g2 = 7'($urandom);
			d = $urandom_range(3) == 0 ? 7'($urandom) : 7'($urandom_range(4, 24));
			c = $urandom_range(4) == 0 ? 7'($urandom) : 7'($urandom_range(1, 8));
			set_regs(g1, g2, d, c);
			run_phase(100);
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d symbol and clear words over %0d register settings",
			words_in, settings_used);
		$display("checked %0d decoded words, %0d mismatches", sb.words_checked, sb.errors);
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("soft_viterbi_decoder_rate_half verification clean");
		else
			$display("soft_viterbi_decoder_rate_half verification failed");
		$finish;
	end
endmodule
